[src/csp_pkg.sv]
// shared types, character codes and helpers for the cigar string parser
package csp_pkg;

  // run length accumulator width
  localparam int LEN_BITS = 28;
  // width of a read or reference position
  localparam int POS_BITS = 31;
  // width of the op_len result field
  localparam int OP_LEN_BITS = 28;
  // width of a signed position field on the result channel
  localparam int SPOS_BITS = 32;

  localparam logic [POS_BITS-1:0] POS_MAX = '1;
  localparam logic [LEN_BITS-1:0] LEN_MAX = '1;
  localparam logic [SPOS_BITS-1:0] POS_NONE = '1;

  // ascii codes the parser reacts to
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_PAD   = 8'h50;
  localparam logic [7:0] CH_M     = 8'h4D;
  localparam logic [7:0] CH_I     = 8'h49;
  localparam logic [7:0] CH_D     = 8'h44;
  localparam logic [7:0] CH_N     = 8'h4E;
  localparam logic [7:0] CH_S     = 8'h53;
  localparam logic [7:0] CH_H     = 8'h48;
  localparam logic [7:0] CH_EQUAL = 8'h3D;
  localparam logic [7:0] CH_X     = 8'h58;

  // operation codes on the result channel
  typedef enum logic [3:0] {
    OP_NONE  = 4'd0,
    OP_M     = 4'd1,
    OP_I     = 4'd2,
    OP_D     = 4'd3,
    OP_N     = 4'd4,
    OP_S     = 4'd5,
    OP_H     = 4'd6,
    OP_EQUAL = 4'd7,
    OP_X     = 4'd8
  } op_t;

  // decoded operation letter
  typedef struct packed {
    logic hit;
    op_t  op;
    logic on_read;
    logic on_ref;
  } op_dec_t;

  // one operation record held for the result channel
  typedef struct packed {
    op_t                    op;
    logic [OP_LEN_BITS-1:0] len;
    logic [SPOS_BITS-1:0]   read_first;
    logic [SPOS_BITS-1:0]   read_last;
    logic [SPOS_BITS-1:0]   ref_first;
    logic [SPOS_BITS-1:0]   ref_last;
  } op_rec_t;

  // map an operation letter to its code and the axes it consumes
  function automatic op_dec_t decode_op(input logic [7:0] c);
    op_dec_t d;
    d = '{hit: 1'b0, op: OP_NONE, on_read: 1'b0, on_ref: 1'b0};
    case (c)
      CH_M:     d = '{hit: 1'b1, op: OP_M,     on_read: 1'b1, on_ref: 1'b1};
      CH_I:     d = '{hit: 1'b1, op: OP_I,     on_read: 1'b1, on_ref: 1'b0};
      CH_D:     d = '{hit: 1'b1, op: OP_D,     on_read: 1'b0, on_ref: 1'b1};
      CH_N:     d = '{hit: 1'b1, op: OP_N,     on_read: 1'b0, on_ref: 1'b1};
      CH_S:     d = '{hit: 1'b1, op: OP_S,     on_read: 1'b1, on_ref: 1'b0};
      CH_H:     d = '{hit: 1'b1, op: OP_H,     on_read: 1'b1, on_ref: 1'b0};
      CH_EQUAL: d = '{hit: 1'b1, op: OP_EQUAL, on_read: 1'b1, on_ref: 1'b1};
      CH_X:     d = '{hit: 1'b1, op: OP_X,     on_read: 1'b1, on_ref: 1'b1};
      default:  d = '{hit: 1'b0, op: OP_NONE,  on_read: 1'b0, on_ref: 1'b0};
    endcase
    return d;
  endfunction

  // clamp a one-bit-wider position sum at the largest position
  function automatic logic [POS_BITS-1:0] sat_pos(input logic [POS_BITS:0] s);
    logic [POS_BITS-1:0] r;
    if (s > {1'b0, POS_MAX}) begin
      r = POS_MAX;
    end else begin
      r = s[POS_BITS-1:0];
    end
    return r;
  endfunction

endpackage

[src/cigar_string_parser.sv]
// cigar string parser: characters in, operation and summary records out
//
//  channel | dir | tdata (low bit up)                               | tuser      | tlast
//  s_*     | in  | ch[7:0], ref_start[38:8], zero pad [39]          | first_char | last_char
//  m_*     | out | op, op_len, read_first, read_last, ref_first,    | kind       | final_result
//          |     | ref_last, read_length, zero pad [191]            |            |
//
// a character passes an input register, then decode, run length update and
// position adds into a result pair register (operation, summary).
// one character per cycle while the receiver is ready, except that a character
// with both an operation record and a summary holds the result register until both are taken.
// rst (synchronous) clears the parse state and both pipeline stages.
// s_tready drops only while the input register is full and the result pair
// cannot be drained in the same cycle.
module cigar_string_parser (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [39:0]  s_tdata,   // ch[7:0], ref_start[38:8], pad[39]
  input  logic         s_tuser,   // first_char
  input  logic         s_tlast,   // last_char
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [191:0] m_tdata,   // op, op_len, read_first, read_last, ref_first,
                                  // ref_last, read_length, pad[191]
  output logic         m_tuser,   // kind
  output logic         m_tlast    // final_result
);

  localparam int AccW = csp_pkg::LEN_BITS + 4;
  localparam int SumW = csp_pkg::POS_BITS + 1;

  // input register
  logic                         in_valid;
  logic [7:0]                   in_ch;
  logic                         in_first;
  logic                         in_last;
  logic [csp_pkg::POS_BITS-1:0] in_ref_start;

  // parse state; the read length seen always equals the next read position
  logic [csp_pkg::LEN_BITS-1:0] acc, acc_next;
  logic [csp_pkg::POS_BITS-1:0] read_pos, read_pos_next;
  logic [csp_pkg::POS_BITS-1:0] ref_pos, ref_pos_next;
  logic                         aborted, aborted_next;

  // result pair register
  logic                         op_valid;
  logic                         sum_valid;
  csp_pkg::op_rec_t             op_rec;
  logic [csp_pkg::POS_BITS-1:0] sum_len;

  // per-character combinational results
  logic                         op_hit;
  csp_pkg::op_rec_t             op_rec_next;
  logic [csp_pkg::POS_BITS-1:0] sum_len_next;

  logic                         load_ok;
  logic                         adv;
  logic                         s_xfer;
  logic                         m_xfer;

  // working values inside the update
  logic [csp_pkg::LEN_BITS-1:0] acc_eff;
  logic [csp_pkg::POS_BITS-1:0] read_eff;
  logic [csp_pkg::POS_BITS-1:0] ref_eff;
  logic                         ab_eff;
  logic [AccW-1:0]              acc_wide;
  logic [3:0]                   digit;
  csp_pkg::op_dec_t             dec;
  logic                         len_nz;

  // handshake and stage movement
  assign s_xfer   = s_tvalid && s_tready;
  assign m_xfer   = m_tvalid && m_tready;
  assign load_ok  = (!op_valid && !sum_valid) || (m_tready && (op_valid != sum_valid));
  assign adv      = in_valid && load_ok;
  assign s_tready = !in_valid || load_ok;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_xfer) begin
      in_valid <= 1'b1;
    end else if (adv) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_xfer) begin
      in_ch        <= s_tdata[7:0];
      in_ref_start <= s_tdata[38:8];
      in_first     <= s_tuser;
      in_last      <= s_tlast;
    end
  end

  // per-character update: new string, digits, letters, pad and star
  always_comb begin
    acc_eff  = in_first ? '0 : acc;
    read_eff = in_first ? '0 : read_pos;
    ref_eff  = in_first ? in_ref_start : ref_pos;
    ab_eff   = in_first ? 1'b0 : aborted;

    digit    = 4'(in_ch - csp_pkg::CH_ZERO);
    acc_wide = ({4'b0, acc_eff} << 3) + ({4'b0, acc_eff} << 1) + AccW'(digit);
    dec      = csp_pkg::decode_op(in_ch);
    len_nz   = (acc_eff != '0);

    acc_next      = acc_eff;
    read_pos_next = read_eff;
    ref_pos_next  = ref_eff;
    aborted_next  = ab_eff;
    op_hit        = 1'b0;
    op_rec_next   = '{op: csp_pkg::OP_NONE, len: '0,
                      read_first: csp_pkg::POS_NONE, read_last: csp_pkg::POS_NONE,
                      ref_first: csp_pkg::POS_NONE, ref_last: csp_pkg::POS_NONE};

    if (!ab_eff) begin
      if (in_ch >= csp_pkg::CH_ZERO && in_ch <= csp_pkg::CH_NINE) begin
        // run length digit, saturating
        if (acc_wide > {4'b0, csp_pkg::LEN_MAX}) begin
          acc_next = csp_pkg::LEN_MAX;
        end else begin
          acc_next = acc_wide[csp_pkg::LEN_BITS-1:0];
        end
      end else if (in_ch == csp_pkg::CH_STAR) begin
        // star: discard marker, rest of the string ignored
        op_hit       = 1'b1;
        acc_next     = '0;
        aborted_next = 1'b1;
      end else if (dec.hit) begin
        // operation letter
        op_hit          = 1'b1;
        op_rec_next.op  = dec.op;
        op_rec_next.len = csp_pkg::OP_LEN_BITS'(acc_eff);
        acc_next        = '0;
        if (len_nz && dec.on_read) begin
          op_rec_next.read_first = {1'b0, read_eff};
          op_rec_next.read_last  = {1'b0, csp_pkg::sat_pos({1'b0, read_eff}
                                     + SumW'(acc_eff) - SumW'(1))};
          read_pos_next          = csp_pkg::sat_pos({1'b0, read_eff} + SumW'(acc_eff));
        end
        if (len_nz && dec.on_ref) begin
          op_rec_next.ref_first = {1'b0, ref_eff};
          op_rec_next.ref_last  = {1'b0, csp_pkg::sat_pos({1'b0, ref_eff}
                                    + SumW'(acc_eff) - SumW'(1))};
          ref_pos_next          = csp_pkg::sat_pos({1'b0, ref_eff} + SumW'(acc_eff));
        end
      end else if (in_ch == csp_pkg::CH_PAD) begin
        // padding clears the number
        acc_next = '0;
      end
    end

    sum_len_next = read_pos_next;
  end

  // parse state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      acc      <= '0;
      read_pos <= '0;
      ref_pos  <= '0;
      aborted  <= 1'b0;
    end else if (adv) begin
      acc      <= acc_next;
      read_pos <= read_pos_next;
      ref_pos  <= ref_pos_next;
      aborted  <= aborted_next;
    end
  end

  // result pair: operation record first, summary second
  always_ff @(posedge clk) begin
    if (rst) begin
      op_valid  <= 1'b0;
      sum_valid <= 1'b0;
    end else if (adv) begin
      op_valid  <= op_hit;
      sum_valid <= in_last;
    end else if (m_xfer) begin
      if (op_valid) begin
        op_valid <= 1'b0;
      end else begin
        sum_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      op_rec  <= op_rec_next;
      sum_len <= sum_len_next;
    end
  end

  // result channel
  assign m_tvalid = op_valid || sum_valid;
  assign m_tuser  = !op_valid;
  assign m_tlast  = !op_valid || !sum_valid;

  always_comb begin
    if (op_valid) begin
      m_tdata = {1'b0, csp_pkg::POS_BITS'(0), op_rec.ref_last, op_rec.ref_first,
                 op_rec.read_last, op_rec.read_first, op_rec.len, op_rec.op};
    end else begin
      m_tdata = {1'b0, sum_len, csp_pkg::POS_NONE, csp_pkg::POS_NONE,
                 csp_pkg::POS_NONE, csp_pkg::POS_NONE,
                 csp_pkg::OP_LEN_BITS'(0), csp_pkg::OP_NONE};
    end
  end

  // checks
  a_no_op_after_star: assert property (@(posedge clk) disable iff (rst)
    (adv && aborted && !in_first) |=> !op_valid)
    else $error("operation record after star");

  a_stall_needs_output: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> m_tvalid)
    else $error("input stalled with no result pending");

  a_read_range_order: assert property (@(posedge clk) disable iff (rst)
    (op_valid && op_rec.read_first != csp_pkg::POS_NONE)
      |-> (op_rec.read_last >= op_rec.read_first))
    else $error("read range reversed");

  a_ref_range_order: assert property (@(posedge clk) disable iff (rst)
    (op_valid && op_rec.ref_first != csp_pkg::POS_NONE)
      |-> (op_rec.ref_last >= op_rec.ref_first))
    else $error("reference range reversed");

endmodule

[dv/csp_checker.sv]
// result checker for the cigar string parser: predicts records per character and compares
module csp_checker (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  input  logic         s_tready,
  input  logic [39:0]  s_tdata,   // ch[7:0], ref_start[38:8], pad[39]
  input  logic         s_tuser,   // first_char
  input  logic         s_tlast,   // last_char
  input  logic         m_tvalid,
  input  logic         m_tready,
  input  logic [191:0] m_tdata,   // op, op_len, read_first, read_last, ref_first,
                                  // ref_last, read_length, pad[191]
  input  logic         m_tuser,   // kind
  input  logic         m_tlast,   // final_result
  output int           err_count,
  output int           pending,
  output int           n_results
);
  timeunit 1ns;
  timeprecision 1ps;

  // one record as seen on the result channel
  typedef struct packed {
    logic                            kind;
    csp_pkg::op_t                    op;
    logic [csp_pkg::OP_LEN_BITS-1:0] op_len;
    logic [csp_pkg::SPOS_BITS-1:0]   read_first;
    logic [csp_pkg::SPOS_BITS-1:0]   read_last;
    logic [csp_pkg::SPOS_BITS-1:0]   ref_first;
    logic [csp_pkg::SPOS_BITS-1:0]   ref_last;
    logic [csp_pkg::POS_BITS-1:0]    read_length;
    logic                            fin;
  } cigar_rec_t;

  // parse state of the predictor
  logic [csp_pkg::LEN_BITS-1:0] run_len;
  logic [csp_pkg::POS_BITS-1:0] read_at;
  logic [csp_pkg::POS_BITS-1:0] ref_at;
  logic [csp_pkg::POS_BITS-1:0] read_total;
  logic                         star_hit;

  cigar_rec_t record_q[$];
  int         err_tally;
  int         result_tally;

  // position add that sticks at the largest position
  function automatic logic [csp_pkg::POS_BITS-1:0] clamp_add(
      input logic [csp_pkg::POS_BITS-1:0] a, input logic [32:0] b);
    logic [33:0] s;
    s = {3'b0, a} + {1'b0, b};
    return (s > {3'b0, csp_pkg::POS_MAX}) ? csp_pkg::POS_MAX : s[csp_pkg::POS_BITS-1:0];
  endfunction

  // record with no operation and no positions (star and summary)
  function automatic cigar_rec_t blank_rec(input logic kind,
                                           input logic [csp_pkg::POS_BITS-1:0] total);
    cigar_rec_t r;
    r.kind        = kind;
    r.op          = csp_pkg::OP_NONE;
    r.op_len      = '0;
    r.read_first  = csp_pkg::POS_NONE;
    r.read_last   = csp_pkg::POS_NONE;
    r.ref_first   = csp_pkg::POS_NONE;
    r.ref_last    = csp_pkg::POS_NONE;
    r.read_length = total;
    r.fin         = 1'b0;
    return r;
  endfunction

  // close the current run as an operation record and advance the positions
  function automatic cigar_rec_t take_run(input csp_pkg::op_t code, input logic on_read,
                                          input logic on_ref);
    cigar_rec_t r;
    r        = blank_rec(1'b0, '0);
    r.op     = code;
    r.op_len = run_len;
    if (run_len != '0 && on_read) begin
      r.read_first = {1'b0, read_at};
      r.read_last  = {1'b0, clamp_add(read_at, {5'd0, run_len} - 33'd1)};
      read_at      = clamp_add(read_at, {5'd0, run_len});
      read_total   = read_at;
    end
    if (run_len != '0 && on_ref) begin
      r.ref_first = {1'b0, ref_at};
      r.ref_last  = {1'b0, clamp_add(ref_at, {5'd0, run_len} - 33'd1)};
      ref_at      = clamp_add(ref_at, {5'd0, run_len});
    end
    run_len = '0;
    return r;
  endfunction

  // work out the records caused by one character and queue them
  task automatic predict_char(input logic [7:0] c, input logic first, input logic last,
                              input logic [csp_pkg::POS_BITS-1:0] start);
    cigar_rec_t   recs [2];
    int           n;
    logic [35:0]  grown;
    logic         hit;
    logic         on_read;
    logic         on_ref;
    csp_pkg::op_t code;
    n       = 0;
    hit     = 1'b0;
    on_read = 1'b0;
    on_ref  = 1'b0;
    code    = csp_pkg::OP_NONE;
    if (first) begin
      run_len    = '0;
      read_at    = '0;
      read_total = '0;
      star_hit   = 1'b0;
      ref_at     = start;
    end
    if (!star_hit) begin
      if (c >= csp_pkg::CH_ZERO && c <= csp_pkg::CH_NINE) begin
        grown   = {8'd0, run_len} * 36'd10 + {28'd0, c - csp_pkg::CH_ZERO};
        run_len = (grown > {8'd0, csp_pkg::LEN_MAX}) ? csp_pkg::LEN_MAX
                                                     : grown[csp_pkg::LEN_BITS-1:0];
      end else begin
        case (c)
          csp_pkg::CH_STAR: begin
            recs[n]  = blank_rec(1'b0, '0);
            n++;
            run_len  = '0;
            star_hit = 1'b1;
          end
          csp_pkg::CH_PAD:   run_len = '0;
          csp_pkg::CH_M:     begin code = csp_pkg::OP_M;     {on_read, on_ref} = 2'b11; end
          csp_pkg::CH_I:     begin code = csp_pkg::OP_I;     {on_read, on_ref} = 2'b10; end
          csp_pkg::CH_D:     begin code = csp_pkg::OP_D;     {on_read, on_ref} = 2'b01; end
          csp_pkg::CH_N:     begin code = csp_pkg::OP_N;     {on_read, on_ref} = 2'b01; end
          csp_pkg::CH_S:     begin code = csp_pkg::OP_S;     {on_read, on_ref} = 2'b10; end
          csp_pkg::CH_H:     begin code = csp_pkg::OP_H;     {on_read, on_ref} = 2'b10; end
          csp_pkg::CH_EQUAL: begin code = csp_pkg::OP_EQUAL; {on_read, on_ref} = 2'b11; end
          csp_pkg::CH_X:     begin code = csp_pkg::OP_X;     {on_read, on_ref} = 2'b11; end
          default:           code = csp_pkg::OP_NONE;
        endcase
        hit = (code != csp_pkg::OP_NONE);
        if (hit) begin
          recs[n] = take_run(code, on_read, on_ref);
          n++;
        end
      end
    end
    if (last) begin
      recs[n] = blank_rec(1'b1, read_total);
      n++;
    end
    if (n > 0) begin
      recs[n-1].fin = 1'b1;
    end
    for (int i = 0; i < n; i++) begin
      record_q.insert(record_q.size(), recs[i]);
    end
  endtask

  function automatic string rec_text(input cigar_rec_t r);
    return $sformatf("kind=%0d op=%0d len=%0d read=%0d..%0d ref=%0d..%0d rlen=%0d fin=%0d",
                     r.kind, r.op, r.op_len, $signed(r.read_first), $signed(r.read_last),
                     $signed(r.ref_first), $signed(r.ref_last), r.read_length, r.fin);
  endfunction

  // compare result transfers first, then predict from the character transfer
  always @(posedge clk) begin : watch
    cigar_rec_t got;
    cigar_rec_t want;
    if (rst) begin
      run_len    = '0;
      read_at    = '0;
      ref_at     = '0;
      read_total = '0;
      star_hit   = 1'b0;
      record_q.delete();
      err_tally    = 0;
      result_tally = 0;
    end else begin
      if (m_tvalid && m_tready) begin
        got.kind        = m_tuser;
        got.op          = csp_pkg::op_t'(m_tdata[3:0]);
        got.op_len      = m_tdata[31:4];
        got.read_first  = m_tdata[63:32];
        got.read_last   = m_tdata[95:64];
        got.ref_first   = m_tdata[127:96];
        got.ref_last    = m_tdata[159:128];
        got.read_length = m_tdata[190:160];
        got.fin         = m_tlast;
        result_tally++;
        if (record_q.size() == 0) begin
          err_tally++;
          if (err_tally <= 10) begin
            $display("%0t: unexpected record %s", $realtime, rec_text(got));
          end
        end else begin
          want = record_q.pop_front();
          if (got !== want) begin
            err_tally++;
            if (err_tally <= 10) begin
              $display("%0t: record mismatch\n  expected %s\n  actual   %s",
                       $realtime, rec_text(want), rec_text(got));
            end
          end
        end
      end
      if (s_tvalid && s_tready) begin
        predict_char(s_tdata[7:0], s_tuser, s_tlast, s_tdata[38:8]);
      end
    end
    err_count <= err_tally;
    n_results <= result_tally;
    pending   <= record_q.size();
  end

endmodule

[dv/cigar_string_parser_tb.sv]
// testbench top for the cigar string parser: clock, reset, character stimulus and verdict
module cigar_string_parser_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [7:0] OP_CHARS [9] = '{csp_pkg::CH_M, csp_pkg::CH_I, csp_pkg::CH_D,
                                           csp_pkg::CH_N, csp_pkg::CH_S, csp_pkg::CH_H,
                                           csp_pkg::CH_EQUAL, csp_pkg::CH_X,
                                           csp_pkg::CH_PAD};
  localparam logic [7:0] READ_CHARS [6] = '{csp_pkg::CH_M, csp_pkg::CH_I, csp_pkg::CH_S,
                                             csp_pkg::CH_H, csp_pkg::CH_EQUAL,
                                             csp_pkg::CH_X};

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [39:0]  s_tdata = '0;    // ch[7:0], ref_start[38:8], pad[39]
  logic         s_tuser = 1'b0;  // first_char
  logic         s_tlast = 1'b0;  // last_char
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [191:0] m_tdata;         // op, op_len, read_first, read_last, ref_first,
                                 // ref_last, read_length, pad[191]
  logic         m_tuser;         // kind
  logic         m_tlast;         // final_result

  int err_count;
  int pending;
  int n_results;
  int src_idle = 0;
  int sink_stall = 0;
  int n_chars = 0;
  int n_strings = 0;
  logic [7:0] text_q[$];

  cigar_string_parser u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  csp_checker u_checker (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast),
    .err_count (err_count),
    .pending   (pending),
    .n_results (n_results)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // receiver stalls at random
  always @(posedge clk) begin
    m_tready <= ($urandom_range(0, 99) >= sink_stall);
  end

  // hard stop if the run hangs
  initial begin
    #5000000;
    $display("DONE: errors detected");
    $finish;
  end

  // one character transfer, with a random idle gap ahead of it
  task automatic send_item(input logic [7:0] c, input logic first, input logic last,
                           input logic [csp_pkg::POS_BITS-1:0] start);
    while ($urandom_range(0, 99) < src_idle) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {1'b0, start, c};
    s_tuser  <= first;
    s_tlast  <= last;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    n_chars++;
  endtask

  // append one character to the string being built
  task automatic add_char(input logic [7:0] c);
    text_q.insert(text_q.size(), c);
  endtask

  // send the queued characters as one string
  task automatic send_queue(input logic [csp_pkg::POS_BITS-1:0] start, input logic mark_first,
                            input logic mark_last);
    for (int i = 0; i < text_q.size(); i++) begin
      send_item(text_q[i], mark_first && i == 0, mark_last && i == text_q.size() - 1,
                (i == 0) ? start : csp_pkg::POS_BITS'($urandom));
    end
  endtask

  task automatic send_text(input string s, input logic [csp_pkg::POS_BITS-1:0] start);
    text_q.delete();
    for (int i = 0; i < s.len(); i++) add_char(s[i]);
    send_queue(start, 1'b1, 1'b1);
    n_strings++;
  endtask

  task automatic push_num(input int unsigned v);
    string digits;
    digits = $sformatf("%0d", v);
    for (int i = 0; i < digits.len(); i++) add_char(digits[i]);
  endtask

  // sender pauses until every expected record has come back
  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // random strings under one idle/stall mix, mostly well formed
  task automatic run_phase(input int idle, input int stall, input int budget);
    int                           base;
    int                           n_ops;
    int                           pick;
    logic [csp_pkg::POS_BITS-1:0] start;
    logic                         mark_first;
    logic                         mark_last;
    src_idle   = idle;
    sink_stall = stall;
    base       = n_chars;
    while (n_chars - base < budget) begin
      text_q.delete();
      if ($urandom_range(0, 99) < 3) begin
        // saturated runs drive the read position into its ceiling
        repeat (9) begin
          push_num(999999999);
          add_char(READ_CHARS[$urandom_range(0, 5)]);
        end
      end else begin
        n_ops = $urandom_range(1, 6);
        for (int k = 0; k < n_ops; k++) begin
          // run length: usual, empty, zero, overlong or with leading zeros
          pick = $urandom_range(0, 99);
          if (pick >= 8) begin
            if (pick < 78) begin
              push_num($urandom_range(1, 999));
            end else if (pick < 85) begin
              add_char(csp_pkg::CH_ZERO);
            end else if (pick < 92) begin
              repeat ($urandom_range(10, 12)) begin
                add_char(csp_pkg::CH_ZERO + 8'($urandom_range(0, 9)));
              end
            end else begin
              add_char(csp_pkg::CH_ZERO);
              push_num($urandom_range(0, 99));
            end
          end
          // occasional noise byte or star ahead of the letter
          if ($urandom_range(0, 99) < 8) add_char(8'($urandom));
          if ($urandom_range(0, 99) < 4) add_char(csp_pkg::CH_STAR);
          add_char(OP_CHARS[$urandom_range(0, 8)]);
        end
        if ($urandom_range(0, 19) == 0) add_char(8'($urandom));
      end
      // start position: near zero, near the ceiling, or anywhere
      case ($urandom_range(0, 3))
        0:       start = csp_pkg::POS_BITS'($urandom_range(0, 1000));
        1:       start = csp_pkg::POS_MAX - csp_pkg::POS_BITS'($urandom_range(0, 2000));
        default: start = csp_pkg::POS_BITS'($urandom);
      endcase
      mark_first = ($urandom_range(0, 19) != 0);
      mark_last  = ($urandom_range(0, 19) != 0);
      send_queue(start, mark_first, mark_last);
      n_strings++;
    end
    drain();
  endtask

  // main sequence
  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // directed: every letter with ref overflow, pad and noise, star abort, lone star
    send_text("1M2I3D4N5S6H7=8X", csp_pkg::POS_MAX - 31'd12);
    send_text("3P#M", '0);
    send_text("2M*5M", 31'd100);
    send_text("*", csp_pkg::POS_MAX);
    drain();

    run_phase(0, 0, 250);
    run_phase(83, 0, 250);
    run_phase(0, 83, 250);
    run_phase(26, 26, 250);

    repeat (8) @(posedge clk);
    $display("sent %0d characters in %0d strings under four idle/stall mixes",
             n_chars, n_strings);
    $display("checked %0d records: all letters, pad, star, saturation, unmarked strings",
             n_results);
    if (err_count == 0 && pending == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
